### src/assert_macros.svh
// Assertion macros for the checker file of the parking sequencer.
// Each macro expands to one labeled concurrent assertion with its own clock and reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

### src/pms_pkg.sv
// Package for the parking maneuver sequencer: widths, phase codes, field positions and
// the table of timed phases. No dependencies.
`timescale 1ns / 1ps

package pms_pkg;

    localparam int DIST_BITS      = 12;
    localparam int GAP_TIMER_BITS = 16;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_ADDR_W-1:0] REG_GAP_DETECT = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_REAR_STOP  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_MIN_GAP    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_SEARCH_DTY = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_FINAL_DTY  = 3'd4;

    localparam int IN_DATA_W  = ((2 * DIST_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_W = 32;

    // Output tdata bit positions.
    localparam int O_LF    = 0;
    localparam int O_LD    = 1;
    localparam int O_RF    = 9;
    localparam int O_RD    = 10;
    localparam int O_BZ    = 18;
    localparam int O_BP    = 20;
    localparam int O_LAMPS = 29;
    localparam int O_BUSY  = 30;
    localparam int O_FIN   = 31;

    // Distances are compared at this width so that every threshold fits.
    localparam int CMP_W = 16;

    localparam int TIMER_W = 11;
    localparam logic [TIMER_W-1:0] SHOW_MS = 11'd2000;

    localparam logic [1:0] BZ_OFF        = 2'd0;
    localparam logic [1:0] BZ_PERIODIC   = 2'd1;
    localparam logic [1:0] BZ_CONTINUOUS = 2'd2;

    typedef enum logic [11:0] {
        PH_IDLE   = 12'b0000_0000_0001,
        PH_SEARCH = 12'b0000_0000_0010,
        PH_STOP_A = 12'b0000_0000_0100,
        PH_BACK_A = 12'b0000_0000_1000,
        PH_STOP_B = 12'b0000_0001_0000,
        PH_TURN_R = 12'b0000_0010_0000,
        PH_STOP_C = 12'b0000_0100_0000,
        PH_TURN_L = 12'b0000_1000_0000,
        PH_STOP_D = 12'b0001_0000_0000,
        PH_NUDGE  = 12'b0010_0000_0000,
        PH_FINAL  = 12'b0100_0000_0000,
        PH_SHOW   = 12'b1000_0000_0000
    } phase_t;

    typedef struct packed {
        logic [TIMER_W-1:0] dur;
        logic               lf;
        logic [7:0]         ld;
        logic               rf;
        logic [7:0]         rd;
        phase_t             succ;
    } timed_t;

    function automatic timed_t timed_entry(input phase_t ph);
        timed_t e;
        e = '{dur: '0, lf: 1'b0, ld: 8'd0, rf: 1'b0, rd: 8'd0, succ: PH_IDLE};
        case (ph)
            PH_STOP_A: e = '{dur: 11'd500,  lf: 1'b0, ld: 8'd0,   rf: 1'b0, rd: 8'd0,
                             succ: PH_BACK_A};
            PH_BACK_A: e = '{dur: 11'd1450, lf: 1'b0, ld: 8'd90,  rf: 1'b0, rd: 8'd90,
                             succ: PH_STOP_B};
            PH_STOP_B: e = '{dur: 11'd500,  lf: 1'b0, ld: 8'd0,   rf: 1'b0, rd: 8'd0,
                             succ: PH_TURN_R};
            PH_TURN_R: e = '{dur: 11'd800,  lf: 1'b1, ld: 8'd255, rf: 1'b1, rd: 8'd80,
                             succ: PH_STOP_C};
            PH_STOP_C: e = '{dur: 11'd500,  lf: 1'b0, ld: 8'd0,   rf: 1'b0, rd: 8'd0,
                             succ: PH_TURN_L};
            PH_TURN_L: e = '{dur: 11'd555,  lf: 1'b0, ld: 8'd80,  rf: 1'b0, rd: 8'd255,
                             succ: PH_STOP_D};
            PH_STOP_D: e = '{dur: 11'd500,  lf: 1'b0, ld: 8'd0,   rf: 1'b0, rd: 8'd0,
                             succ: PH_NUDGE};
            PH_NUDGE:  e = '{dur: 11'd50,   lf: 1'b0, ld: 8'd100, rf: 1'b0, rd: 8'd100,
                             succ: PH_FINAL};
            default:   e = '{dur: '0, lf: 1'b0, ld: 8'd0, rf: 1'b0, rd: 8'd0, succ: PH_IDLE};
        endcase
        return e;
    endfunction

endpackage

### src/parking_maneuver_sequencer.sv
// Parking maneuver sequencer top level: phase state, gap timer, buzzer bands, output register.
// Depends on pms_pkg.
//
// Channel      Direction  Handshake                       Contents
// s_axis       in         s_axis_tvalid / s_axis_tready   tuser op, tdata side and rear distance
// m_axis       out        m_axis_tvalid / m_axis_tready   tdata motor, buzzer, lamp and status
// cfg          in         cfg_we                          cfg_addr register index, cfg_wdata
//
// Every transaction is handled combinationally and its result appears in the output register
// on the next cycle, so one item per clock is sustained while the output is not stalled.
// The input is ready whenever the output register is empty or is being taken in the same cycle.
// Reset puts the sequencer in the idle phase; all registers but the output data are reset.
// A stall on the output holds the result and the input stops after one waiting result.
`timescale 1ns / 1ps

module parking_maneuver_sequencer (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // Fields from bit 0: side_mm, rear_mm.
    input  logic [pms_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // Fields from bit 0: op.
    input  logic                            s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // Fields from bit 0: left_forward, left_duty, right_forward, right_duty, buzzer_mode,
    // beep_period_ms, lamps_on, busy_res, finished.
    output logic [pms_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    input  logic                            cfg_we,
    input  logic [pms_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [pms_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import pms_pkg::*;

    logic [11:0]               gap_detect_reg;
    logic [11:0]               rear_stop_reg;
    logic [15:0]               min_gap_reg;
    logic [7:0]                search_duty_reg;
    logic [7:0]                final_duty_reg;

    phase_t                    phase_reg, phase_next;
    logic [TIMER_W-1:0]        timer_reg, timer_next;
    logic                      gap_open_reg, gap_open_next;
    logic [GAP_TIMER_BITS-1:0] gap_len_reg, gap_len_next;
    logic                      beep_en_reg, beep_en_next;
    logic [8:0]                beep_per_reg, beep_per_next;

    logic                      out_valid_reg;
    logic [OUT_DATA_W-1:0]     out_data_reg, out_data_next;

    logic                      accept;
    logic [DIST_BITS-1:0]      side;
    logic [DIST_BITS-1:0]      rear;
    logic [CMP_W-1:0]          side_x;
    logic [CMP_W-1:0]          rear_x;
    logic [GAP_TIMER_BITS-1:0] gap_inc;
    logic [TIMER_W-1:0]        timer_inc;
    logic                      fin;
    timed_t                    cur_entry;
    timed_t                    nxt_entry;
    logic                      lf, rf, lamps;
    logic [7:0]                ld, rd;
    logic [1:0]                bz;
    logic [8:0]                bp;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    assign side      = s_axis_tdata[DIST_BITS-1:0];
    assign rear      = s_axis_tdata[2*DIST_BITS-1:DIST_BITS];
    assign side_x    = CMP_W'(side);
    assign rear_x    = CMP_W'(rear);
    assign gap_inc   = (gap_len_reg != '1) ? gap_len_reg + 1'b1 : gap_len_reg;
    assign timer_inc = timer_reg + 1'b1;
    assign cur_entry = timed_entry(phase_reg);
    assign nxt_entry = timed_entry(phase_next);

    always_comb
    begin
        phase_next    = phase_reg;
        timer_next    = timer_reg;
        gap_open_next = gap_open_reg;
        gap_len_next  = gap_len_reg;
        beep_en_next  = beep_en_reg;
        beep_per_next = beep_per_reg;
        fin           = 1'b0;
        if (s_axis_tuser)
        begin
            if (phase_reg == PH_IDLE)
            begin
                phase_next    = PH_SEARCH;
                timer_next    = '0;
                gap_open_next = 1'b0;
                gap_len_next  = '0;
                beep_en_next  = 1'b0;
                beep_per_next = '0;
            end
        end
        else
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                end
                PH_SEARCH:
                begin
                    if (side_x > CMP_W'(gap_detect_reg))
                    begin
                        gap_open_next = 1'b1;
                        gap_len_next  = gap_open_reg ? gap_inc : '0;
                    end
                    else if (gap_open_reg)
                    begin
                        gap_len_next  = gap_inc;
                        gap_open_next = 1'b0;
                        if (32'(gap_inc) >= 32'(min_gap_reg))
                        begin
                            phase_next = PH_STOP_A;
                            timer_next = '0;
                        end
                    end
                end
                PH_STOP_A, PH_BACK_A, PH_STOP_B, PH_TURN_R, PH_STOP_C, PH_TURN_L,
                PH_STOP_D, PH_NUDGE:
                begin
                    if (timer_inc >= cur_entry.dur)
                    begin
                        phase_next = cur_entry.succ;
                        timer_next = '0;
                    end
                    else
                    begin
                        timer_next = timer_inc;
                    end
                end
                PH_FINAL:
                begin
                    if (rear_x >= CMP_W'(600))
                    begin
                        beep_en_next = 1'b0;
                    end
                    else if (rear_x > CMP_W'(450))
                    begin
                        beep_per_next = 9'd300;
                        beep_en_next  = 1'b1;
                    end
                    else if (rear_x > CMP_W'(300))
                    begin
                        beep_per_next = 9'd150;
                    end
                    else if (rear_x >= CMP_W'(150))
                    begin
                        beep_per_next = 9'd50;
                    end
                    if (rear_x <= CMP_W'(rear_stop_reg))
                    begin
                        beep_en_next = 1'b0;
                        phase_next   = PH_SHOW;
                        timer_next   = '0;
                    end
                end
                PH_SHOW:
                begin
                    if (timer_inc >= SHOW_MS)
                    begin
                        phase_next = PH_IDLE;
                        timer_next = '0;
                        fin        = 1'b1;
                    end
                    else
                    begin
                        timer_next = timer_inc;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                    timer_next = '0;
                end
            endcase
        end
    end

    always_comb
    begin
        lf    = 1'b0;
        ld    = 8'd0;
        rf    = 1'b0;
        rd    = 8'd0;
        bz    = BZ_OFF;
        bp    = 9'd0;
        lamps = 1'b0;
        case (phase_next)
            PH_SEARCH:
            begin
                lf = 1'b1;
                ld = search_duty_reg;
                rf = 1'b1;
                rd = search_duty_reg;
            end
            PH_STOP_A, PH_BACK_A, PH_STOP_B, PH_TURN_R, PH_STOP_C, PH_TURN_L,
            PH_STOP_D, PH_NUDGE:
            begin
                lf = nxt_entry.lf;
                ld = nxt_entry.ld;
                rf = nxt_entry.rf;
                rd = nxt_entry.rd;
            end
            PH_FINAL:
            begin
                ld = final_duty_reg;
                rd = final_duty_reg;
                if (beep_en_next)
                begin
                    bz = BZ_PERIODIC;
                    bp = beep_per_next;
                end
            end
            PH_SHOW:
            begin
                bz    = BZ_CONTINUOUS;
                lamps = 1'b1;
            end
            default:
            begin
            end
        endcase
        out_data_next           = '0;
        out_data_next[O_LF]     = lf && (ld != 8'd0);
        out_data_next[O_LD+:8]  = ld;
        out_data_next[O_RF]     = rf && (rd != 8'd0);
        out_data_next[O_RD+:8]  = rd;
        out_data_next[O_BZ+:2]  = bz;
        out_data_next[O_BP+:9]  = bp;
        out_data_next[O_LAMPS]  = lamps;
        out_data_next[O_BUSY]   = (phase_next != PH_IDLE);
        out_data_next[O_FIN]    = fin;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_detect_reg  <= 12'd350;
            rear_stop_reg   <= 12'd70;
            min_gap_reg     <= 16'd400;
            search_duty_reg <= 8'd80;
            final_duty_reg  <= 8'd60;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_GAP_DETECT: gap_detect_reg  <= cfg_wdata[11:0];
                REG_REAR_STOP:  rear_stop_reg   <= cfg_wdata[11:0];
                REG_MIN_GAP:    min_gap_reg     <= cfg_wdata[15:0];
                REG_SEARCH_DTY: search_duty_reg <= cfg_wdata[7:0];
                REG_FINAL_DTY:  final_duty_reg  <= cfg_wdata[7:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            timer_reg     <= '0;
            gap_open_reg  <= 1'b0;
            gap_len_reg   <= '0;
            beep_en_reg   <= 1'b0;
            beep_per_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg     <= phase_next;
                timer_reg     <= timer_next;
                gap_open_reg  <= gap_open_next;
                gap_len_reg   <= gap_len_next;
                beep_en_reg   <= beep_en_next;
                beep_per_reg  <= beep_per_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

### src/pms_checker.sv
// Port-level checker for the parking maneuver sequencer, attached by a bind statement.
// Depends on pms_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pms_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [pms_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
    import pms_pkg::*;

    `ASSERT_NEXT(a_accept_gives_result, clk, rst_n, s_axis_tvalid && s_axis_tready, m_axis_tvalid)
    `ASSERT_NEXT(a_stall_holds, clk, rst_n, m_axis_tvalid && !m_axis_tready,
                 m_axis_tvalid && $stable(m_axis_tdata))
    `ASSERT_SAME(a_dir_needs_duty, clk, rst_n, m_axis_tvalid && m_axis_tdata[O_LF],
                 m_axis_tdata[O_LD+:8] != 8'd0)
    `ASSERT_SAME(a_period_only_periodic, clk, rst_n,
                 m_axis_tvalid && (m_axis_tdata[O_BZ+:2] != BZ_PERIODIC),
                 m_axis_tdata[O_BP+:9] == 9'd0)
    `ASSERT_SAME(a_lamps_with_tone, clk, rst_n, m_axis_tvalid && m_axis_tdata[O_LAMPS],
                 (m_axis_tdata[O_BZ+:2] == BZ_CONTINUOUS) && m_axis_tdata[O_BUSY])

endmodule

bind parking_maneuver_sequencer pms_checker u_pms_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

### tb/tb_top.sv
// Self-checking testbench for parking_maneuver_sequencer: streams start and tick transactions,
// predicts every report in step with the block, and checks each report field by field.
// Depends on pms_pkg and the parking_maneuver_sequencer RTL.
`timescale 1ns / 1ps

module tb_top;
    import pms_pkg::*;

    localparam int CLK_NS = 12;
    localparam int DISPLAY_MS = 2000;
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_START = 1'b1;
    localparam logic [CFG_ADDR_W-1:0] REG_UNMAPPED = 3'd5;

    typedef struct packed {
        logic       finished;
        logic       busy_res;
        logic       lamps_on;
        logic [8:0] beep_period_ms;
        logic [1:0] buzzer_mode;
        logic [7:0] right_duty;
        logic       right_forward;
        logic [7:0] left_duty;
        logic       left_forward;
    } maneuver_report_t;

    typedef struct packed {
        logic [11:0] span;
        phase_t      succ;
        logic        lf;
        logic [7:0]  ld;
        logic        rf;
        logic [7:0]  rd;
    } move_step_t;

    typedef struct packed {
        logic             op;
        logic [11:0]      side;
        logic [11:0]      rear;
        logic             fixed;
        maneuver_report_t want;
    } stim_row_t;

    localparam maneuver_report_t IDLE_REPORT = '0;
    localparam maneuver_report_t SEARCH_REPORT = '{finished: 1'b0, busy_res: 1'b1,
        lamps_on: 1'b0, beep_period_ms: 9'd0, buzzer_mode: BZ_OFF, right_duty: 8'd80,
        right_forward: 1'b1, left_duty: 8'd80, left_forward: 1'b1};

    localparam stim_row_t DIRECTED_ROWS [12] = '{
        '{OP_TICK,  12'd4095, 12'd4095, 1'b1, IDLE_REPORT},
        '{OP_TICK,  12'd0,    12'd0,    1'b1, IDLE_REPORT},
        '{OP_TICK,  12'd2730, 12'd1365, 1'b1, IDLE_REPORT},
        '{OP_START, 12'd4095, 12'd4095, 1'b1, SEARCH_REPORT},
        '{OP_START, 12'd0,    12'd0,    1'b1, SEARCH_REPORT},
        '{OP_TICK,  12'd0,    12'd4095, 1'b0, IDLE_REPORT},
        '{OP_TICK,  12'd4095, 12'd0,    1'b0, IDLE_REPORT},
        '{OP_TICK,  12'd351,  12'd1365, 1'b0, IDLE_REPORT},
        '{OP_TICK,  12'd350,  12'd2730, 1'b0, IDLE_REPORT},
        '{OP_TICK,  12'd1365, 12'd0,    1'b0, IDLE_REPORT},
        '{OP_TICK,  12'd0,    12'd0,    1'b0, IDLE_REPORT},
        '{OP_START, 12'd2730, 12'd1365, 1'b1, SEARCH_REPORT}
    };

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata;
    logic                   s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;
    logic                   cfg_we;
    logic [CFG_ADDR_W-1:0]  cfg_addr;
    logic [CFG_DATA_W-1:0]  cfg_wdata;

    bit jitter_on = 1'b1;
    int mismatches = 0;
    maneuver_report_t expected_reports [$];

    phase_t      model_phase;
    int unsigned model_ms;
    bit          model_gap_open;
    logic [15:0] model_gap_ms;
    bit          model_beeping;
    logic [8:0]  model_beep_ms;
    logic [11:0] cfg_gap_mm;
    logic [11:0] cfg_rear_mm;
    logic [15:0] cfg_min_gap;
    logic [7:0]  cfg_search_duty;
    logic [7:0]  cfg_final_duty;

    parking_maneuver_sequencer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    always
    begin
        #(CLK_NS / 2) clk = 1'b1;
        #(CLK_NS / 2) clk = 1'b0;
    end

    function automatic bit in_timed_move(input phase_t p);
        case (p)
            PH_STOP_A, PH_BACK_A, PH_STOP_B, PH_TURN_R, PH_STOP_C, PH_TURN_L, PH_STOP_D,
            PH_NUDGE: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic move_step_t move_step(input phase_t p);
        case (p)
            PH_STOP_A: return '{12'd500,  PH_BACK_A, 1'b0, 8'd0,   1'b0, 8'd0};
            PH_BACK_A: return '{12'd1450, PH_STOP_B, 1'b0, 8'd90,  1'b0, 8'd90};
            PH_STOP_B: return '{12'd500,  PH_TURN_R, 1'b0, 8'd0,   1'b0, 8'd0};
            PH_TURN_R: return '{12'd800,  PH_STOP_C, 1'b1, 8'd255, 1'b1, 8'd80};
            PH_STOP_C: return '{12'd500,  PH_TURN_L, 1'b0, 8'd0,   1'b0, 8'd0};
            PH_TURN_L: return '{12'd555,  PH_STOP_D, 1'b0, 8'd80,  1'b0, 8'd255};
            PH_STOP_D: return '{12'd500,  PH_NUDGE,  1'b0, 8'd0,   1'b0, 8'd0};
            PH_NUDGE:  return '{12'd50,   PH_FINAL,  1'b0, 8'd100, 1'b0, 8'd100};
            default:   return '{12'd0,    PH_IDLE,   1'b0, 8'd0,   1'b0, 8'd0};
        endcase
    endfunction

    function automatic maneuver_report_t advance_maneuver(input logic op,
                                                          input logic [11:0] side,
                                                          input logic [11:0] rear);
        maneuver_report_t rpt;
        move_step_t st;
        rpt = '0;
        if (op == OP_START)
        begin
            if (model_phase == PH_IDLE)
            begin
                model_phase = PH_SEARCH;
                model_ms = 0;
                model_gap_open = 1'b0;
                model_gap_ms = '0;
                model_beeping = 1'b0;
                model_beep_ms = '0;
            end
        end
        else if (model_phase == PH_SEARCH)
        begin
            if (side > cfg_gap_mm)
            begin
                if (!model_gap_open)
                begin
                    model_gap_open = 1'b1;
                    model_gap_ms = '0;
                end
                else if (model_gap_ms != '1)
                    model_gap_ms++;
            end
            else if (model_gap_open)
            begin
                if (model_gap_ms != '1)
                    model_gap_ms++;
                model_gap_open = 1'b0;
                if (model_gap_ms >= cfg_min_gap)
                begin
                    model_phase = PH_STOP_A;
                    model_ms = 0;
                end
            end
        end
        else if (in_timed_move(model_phase))
        begin
            st = move_step(model_phase);
            model_ms++;
            if (model_ms >= st.span)
            begin
                model_phase = st.succ;
                model_ms = 0;
            end
        end
        else if (model_phase == PH_FINAL)
        begin
            if (rear >= 600)
                model_beeping = 1'b0;
            else if (rear > 450)
            begin
                model_beep_ms = 9'd300;
                model_beeping = 1'b1;
            end
            else if (rear > 300)
                model_beep_ms = 9'd150;
            else if (rear >= 150)
                model_beep_ms = 9'd50;
            if (rear <= cfg_rear_mm)
            begin
                model_beeping = 1'b0;
                model_phase = PH_SHOW;
                model_ms = 0;
            end
        end
        else if (model_phase == PH_SHOW)
        begin
            model_ms++;
            if (model_ms >= DISPLAY_MS)
            begin
                model_phase = PH_IDLE;
                model_ms = 0;
                rpt.finished = 1'b1;
            end
        end

        case (model_phase)
            PH_IDLE: ;
            PH_SEARCH:
            begin
                rpt.left_forward = 1'b1;
                rpt.left_duty = cfg_search_duty;
                rpt.right_forward = 1'b1;
                rpt.right_duty = cfg_search_duty;
            end
            PH_FINAL:
            begin
                rpt.left_duty = cfg_final_duty;
                rpt.right_duty = cfg_final_duty;
                if (model_beeping)
                begin
                    rpt.buzzer_mode = BZ_PERIODIC;
                    rpt.beep_period_ms = model_beep_ms;
                end
            end
            PH_SHOW:
            begin
                rpt.buzzer_mode = BZ_CONTINUOUS;
                rpt.lamps_on = 1'b1;
            end
            default:
            begin
                st = move_step(model_phase);
                rpt.left_forward = st.lf;
                rpt.left_duty = st.ld;
                rpt.right_forward = st.rf;
                rpt.right_duty = st.rd;
            end
        endcase
        if (rpt.left_duty == 0)
            rpt.left_forward = 1'b0;
        if (rpt.right_duty == 0)
            rpt.right_forward = 1'b0;
        rpt.busy_res = (model_phase != PH_IDLE);
        return rpt;
    endfunction

    task automatic send_item(input logic op, input logic [11:0] side, input logic [11:0] rear,
                             input logic fixed, input maneuver_report_t want);
        maneuver_report_t predicted;
        if (jitter_on && $urandom_range(0, 7) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= {rear, side};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predicted = advance_maneuver(op, side, rear);
        expected_reports.push_back(fixed ? want : predicted);
    endtask

    task automatic tick(input logic [11:0] side, input logic [11:0] rear);
        send_item(OP_TICK, side, rear, 1'b0, IDLE_REPORT);
    endtask

    task automatic start_req();
        send_item(OP_START, 12'($urandom), 12'($urandom), 1'b0, IDLE_REPORT);
    endtask

    function automatic logic [11:0] side_value(input bit above);
        int unsigned lo;
        lo = cfg_gap_mm;
        if (above)
            return 12'($urandom_range(4095, lo + 1));
        return 12'($urandom_range(lo, 0));
    endfunction

    task automatic drain_reports();
        s_axis_tvalid <= 1'b0;
        while (expected_reports.size() != 0)
            @(posedge clk);
    endtask

    // Leaves cfg_we high; the caller lowers it after its last write.
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [15:0] value);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        case (idx)
            REG_GAP_DETECT: cfg_gap_mm = value[11:0];
            REG_REAR_STOP:  cfg_rear_mm = value[11:0];
            REG_MIN_GAP:    cfg_min_gap = value;
            REG_SEARCH_DTY: cfg_search_duty = value[7:0];
            REG_FINAL_DTY:  cfg_final_duty = value[7:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [15:0] gap, input logic [15:0] rear_stop,
                                  input logic [15:0] min_gap, input logic [15:0] sduty,
                                  input logic [15:0] fduty);
        drain_reports();
        write_reg(REG_GAP_DETECT, gap);
        write_reg(REG_REAR_STOP, rear_stop);
        write_reg(REG_MIN_GAP, min_gap);
        write_reg(REG_SEARCH_DTY, sduty);
        write_reg(REG_FINAL_DTY, fduty);
        cfg_we <= 1'b0;
    endtask

    task automatic run_maneuver(input bit complete);
        int gap_ticks;
        int step_max;
        int cfg_at;
        int count;
        logic [11:0] rear_now;
        repeat ($urandom_range(1, 12))
            send_item(1'($urandom), 12'($urandom), 12'($urandom), 1'b0, IDLE_REPORT);
        if (model_phase == PH_IDLE)
            start_req();
        if (!complete)
        begin
            repeat (100)
                tick(12'($urandom), 12'($urandom));
            return;
        end

        while (model_phase == PH_SEARCH)
        begin
            repeat ($urandom_range(1, 6))
                tick(side_value(1'b0), 12'($urandom));
            case ($urandom_range(0, 3))
                0: gap_ticks = cfg_min_gap + $urandom_range(0, 2);
                1: gap_ticks = (cfg_min_gap == 0) ? 0 : cfg_min_gap - 1;
                default: gap_ticks = $urandom_range(0, cfg_min_gap);
            endcase
            repeat (gap_ticks)
            begin
                if ($urandom_range(0, 39) == 0)
                    start_req();
                tick(side_value(1'b1), 12'($urandom));
            end
        end

        while (in_timed_move(model_phase))
        begin
            if ($urandom_range(0, 63) == 0)
                start_req();
            else
                tick(12'($urandom), 12'($urandom));
        end

        rear_now = 12'($urandom);
        step_max = $urandom_range(1, 40);
        cfg_at = $urandom_range(1, 30);
        count = 0;
        while (model_phase == PH_FINAL)
        begin
            count++;
            if (count == cfg_at)
            begin
                drain_reports();
                write_reg(REG_FINAL_DTY, 16'($urandom));
                write_reg(3'($urandom_range(7, REG_UNMAPPED)), 16'($urandom));
                cfg_we <= 1'b0;
            end
            if ($urandom_range(0, 24) == 0)
                tick(12'($urandom), 12'($urandom));
            else
            begin
                gap_ticks = $urandom_range(0, step_max);
                rear_now = (rear_now > gap_ticks) ? rear_now - 12'(gap_ticks) : 12'd0;
                tick(12'($urandom), rear_now);
            end
        end

        while (model_phase == PH_SHOW)
        begin
            if ($urandom_range(0, 63) == 0)
                start_req();
            else
                tick(12'($urandom), 12'($urandom));
        end
        repeat ($urandom_range(1, 4))
            tick(12'($urandom), 12'($urandom));
    endtask

    always @(posedge clk)
    begin : report_check
        maneuver_report_t got;
        maneuver_report_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata;
            if (expected_reports.size() == 0)
            begin
                $error("report transaction with none expected: %h", m_axis_tdata);
                mismatches++;
            end
            else
            begin
                want = expected_reports.pop_front();
                if (got.left_forward !== want.left_forward)
                begin
                    $error("left_forward: expected %0d, got %0d",
                           want.left_forward, got.left_forward);
                    mismatches++;
                end
                if (got.left_duty !== want.left_duty)
                begin
                    $error("left_duty: expected %0d, got %0d", want.left_duty, got.left_duty);
                    mismatches++;
                end
                if (got.right_forward !== want.right_forward)
                begin
                    $error("right_forward: expected %0d, got %0d",
                           want.right_forward, got.right_forward);
                    mismatches++;
                end
                if (got.right_duty !== want.right_duty)
                begin
                    $error("right_duty: expected %0d, got %0d", want.right_duty, got.right_duty);
                    mismatches++;
                end
                if (got.buzzer_mode !== want.buzzer_mode)
                begin
                    $error("buzzer_mode: expected %0d, got %0d",
                           want.buzzer_mode, got.buzzer_mode);
                    mismatches++;
                end
                if (got.beep_period_ms !== want.beep_period_ms)
                begin
                    $error("beep_period_ms: expected %0d, got %0d",
                           want.beep_period_ms, got.beep_period_ms);
                    mismatches++;
                end
                if (got.lamps_on !== want.lamps_on)
                begin
                    $error("lamps_on: expected %0d, got %0d", want.lamps_on, got.lamps_on);
                    mismatches++;
                end
                if (got.busy_res !== want.busy_res)
                begin
                    $error("busy_res: expected %0d, got %0d", want.busy_res, got.busy_res);
                    mismatches++;
                end
                if (got.finished !== want.finished)
                begin
                    $error("finished: expected %0d, got %0d", want.finished, got.finished);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        m_axis_tready = 1'b0;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (jitter_on && $urandom_range(0, 7) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
        end
    end

    initial
    begin
        #(CLK_NS * 5_000_000);
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = OP_TICK;
        cfg_we = 1'b0;
        cfg_addr = REG_GAP_DETECT;
        cfg_wdata = '0;
        model_phase = PH_IDLE;
        model_ms = 0;
        model_gap_open = 1'b0;
        model_gap_ms = '0;
        model_beeping = 1'b0;
        model_beep_ms = '0;
        cfg_gap_mm = 12'd350;
        cfg_rear_mm = 12'd70;
        cfg_min_gap = 16'd400;
        cfg_search_duty = 8'd80;
        cfg_final_duty = 8'd60;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < 12; i++)
            send_item(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].side, DIRECTED_ROWS[i].rear,
                      DIRECTED_ROWS[i].fixed, DIRECTED_ROWS[i].want);

        apply_settings(16'd350, 16'd70, 16'd400, 16'd80, 16'd60);
        run_maneuver(1'b1);
        apply_settings(16'd0, 16'd4095, 16'd0, 16'd255, 16'd255);
        run_maneuver(1'b1);
        apply_settings(16'd4095, 16'd0, 16'd65535, 16'd0, 16'd0);
        run_maneuver(1'b0);
        apply_settings(16'($urandom_range(100, 3000)), 16'd0, 16'($urandom_range(1, 300)),
                       16'($urandom), 16'd0);
        run_maneuver(1'b1);
        apply_settings({4'($urandom), 12'($urandom_range(100, 3000))}, 16'($urandom),
                       16'($urandom_range(1, 300)), 16'($urandom), 16'($urandom));
        run_maneuver(1'b1);

        // A gap longer than the gap timer can count must still pass the largest minimum.
        jitter_on = 1'b0;
        apply_settings(16'd1000, 16'($urandom), 16'd65535, 16'($urandom), 16'($urandom));
        if (model_phase == PH_IDLE)
            start_req();
        repeat (3)
            tick(side_value(1'b0), 12'($urandom));
        repeat (65536 + $urandom_range(0, 40))
            tick(side_value(1'b1), 12'($urandom));
        tick(side_value(1'b0), 12'($urandom));
        repeat (200)
            tick(12'($urandom), 12'($urandom));

        drain_reports();
        repeat (4) @(posedge clk);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
